>>> hw/rtl/mqps_pkg.sv
package mqps_pkg;

  localparam int NUM_QUEUES    = 3;
  localparam int QUEUE_DEPTH   = 64;
  localparam int PRIORITY_BITS = 4;
  localparam int TICKET_BITS   = 16;
  localparam int FILL_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int QSEL_W        = 2;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_POP    = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_SERVED   = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FULL     = 3'd3,
    ST_BADQ     = 3'd4,
    ST_CLEARED  = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0]               cmd;
    logic [QSEL_W-1:0]        queue_sel;
    logic [PRIORITY_BITS-1:0] priority_req;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]             status;
    logic [TICKET_BITS-1:0] ticket;
  } out_beat_t;

  typedef struct packed {
    logic [PRIORITY_BITS-1:0] prio;
    logic [TICKET_BITS-1:0]   tick;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic pop;
    logic clr;
  } qctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

>>> hw/rtl/multi_queue_priority_fifo_scheduler.sv
// Multi-queue stable priority scheduler.
// Command channel: drive in_data (cmd, queue_sel, priority_req) with start
// high; a beat is taken at any rising edge where start is high and busy is
// low. busy stays low, so one command can be taken every cycle.
// Commands: insert stores (priority, ticket) in the selected queue and
// returns the new ticket; pop returns and removes the highest priority
// entry, earliest ticket first among equals; clear empties all queues and
// restarts the ticket counter at zero.
// Result channel: exactly one result beat per command, on out_data with
// out_valid high for one cycle, in the cycle after the command is taken.
// Throughput 1 command per cycle; each queue is a row of
// cells that compare against the new priority and shift in parallel.
// The receiver cannot stall; a result not captured in its cycle is gone.
// Reset (rst_n low, synchronous) empties every queue, zeroes the counter
// and drops any pending result beat.
module multi_queue_priority_fifo_scheduler (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mqps_pkg::in_beat_t  in_data,
  output logic                out_valid,
  output mqps_pkg::out_beat_t out_data
);

  localparam int NQ = mqps_pkg::NUM_QUEUES;
  localparam int TW = mqps_pkg::TICKET_BITS;

  logic [TW-1:0]       arrival_r;
  logic [TW-1:0]       arrival_nxt;
  logic                out_valid_r;
  mqps_pkg::out_beat_t out_data_r;
  mqps_pkg::out_beat_t out_data_nxt;

  mqps_pkg::qctl_t  qctl [NQ];
  mqps_pkg::entry_t qhead [NQ];
  mqps_pkg::qstat_t qstat [NQ];
  mqps_pkg::entry_t new_e;

  logic             q_ok;
  logic             sat;
  mqps_pkg::qstat_t sel_stat;
  mqps_pkg::entry_t sel_head;
  logic             do_ins;
  logic             do_pop;
  logic             do_clr;

  assign busy      = 1'b0;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign q_ok = (in_data.queue_sel < mqps_pkg::QSEL_W'(NQ));
  assign sat  = (arrival_r == '1);

  assign new_e.prio = in_data.priority_req;
  assign new_e.tick = arrival_r + TW'(1);

  always_comb begin
    sel_stat = '0;
    sel_head = '0;
    for (int q = 0; q < NQ; q++) begin
      if (in_data.queue_sel == mqps_pkg::QSEL_W'(q)) begin
        sel_stat = qstat[q];
        sel_head = qhead[q];
      end
    end
  end

  always_comb begin
    do_ins       = 1'b0;
    do_pop       = 1'b0;
    do_clr       = 1'b0;
    arrival_nxt  = arrival_r;
    out_data_nxt = '{status: mqps_pkg::ST_BADQ, ticket: '0};
    unique case (in_data.cmd)
      mqps_pkg::CMD_INSERT: begin
        if (!q_ok) begin
          if (!sat) begin
            arrival_nxt = arrival_r + TW'(1);
          end
        end else if (sel_stat.full || sat) begin
          out_data_nxt.status = mqps_pkg::ST_FULL;
        end else begin
          do_ins              = 1'b1;
          arrival_nxt         = new_e.tick;
          out_data_nxt.status = mqps_pkg::ST_INSERTED;
          out_data_nxt.ticket = new_e.tick;
        end
      end
      mqps_pkg::CMD_POP: begin
        if (q_ok) begin
          if (sel_stat.empty) begin
            out_data_nxt.status = mqps_pkg::ST_EMPTY;
          end else begin
            do_pop              = 1'b1;
            out_data_nxt.status = mqps_pkg::ST_SERVED;
            out_data_nxt.ticket = sel_head.tick;
          end
        end
      end
      mqps_pkg::CMD_CLEAR: begin
        do_clr              = 1'b1;
        arrival_nxt         = '0;
        out_data_nxt.status = mqps_pkg::ST_CLEARED;
      end
      default: begin
        out_data_nxt.status = mqps_pkg::ST_BADQ;
      end
    endcase
  end

  genvar g;
  generate
    for (g = 0; g < NQ; g++) begin : g_q
      logic hit;
      assign hit          = start && (in_data.queue_sel == mqps_pkg::QSEL_W'(g));
      assign qctl[g].ins  = hit && do_ins;
      assign qctl[g].pop  = hit && do_pop;
      assign qctl[g].clr  = start && do_clr;
      mqps_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (qctl[g]),
        .new_e (new_e),
        .head  (qhead[g]),
        .stat  (qstat[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arrival_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= start;
      if (start) begin
        arrival_r <= arrival_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

>>> hw/rtl/mqps_cell.sv
module mqps_cell (
  input  logic            clk,
  input  mqps_pkg::qctl_t ctl,
  input  logic            valid,
  input  mqps_pkg::entry_t new_e,
  input  mqps_pkg::entry_t prev_e,
  input  logic            prev_disp,
  input  mqps_pkg::entry_t next_e,
  output mqps_pkg::entry_t e,
  output logic            disp
);

  mqps_pkg::entry_t e_r;
  mqps_pkg::entry_t e_nxt;

  assign e    = e_r;
  assign disp = !valid || (new_e.prio > e_r.prio);

  always_comb begin
    e_nxt = e_r;
    if (ctl.ins && disp) begin
      e_nxt = prev_disp ? prev_e : new_e;
    end else if (ctl.pop) begin
      e_nxt = next_e;
    end
  end

  always_ff @(posedge clk) begin
    e_r <= e_nxt;
  end

endmodule

>>> hw/rtl/mqps_queue.sv
module mqps_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  mqps_pkg::qctl_t  ctl,
  input  mqps_pkg::entry_t new_e,
  output mqps_pkg::entry_t head,
  output mqps_pkg::qstat_t stat
);

  localparam int D = mqps_pkg::QUEUE_DEPTH;
  localparam int W = mqps_pkg::FILL_W;

  logic [W-1:0]     fill_r;
  logic [W-1:0]     fill_nxt;
  mqps_pkg::entry_t ent [D];
  logic             disp [D];

  genvar i;
  generate
    for (i = 0; i < D; i++) begin : g_cell
      mqps_pkg::entry_t prev_e;
      mqps_pkg::entry_t next_e;
      logic             prev_disp;
      if (i == 0) begin : g_first
        assign prev_e    = ent[0];
        assign prev_disp = 1'b0;
      end else begin : g_mid
        assign prev_e    = ent[i-1];
        assign prev_disp = disp[i-1];
      end
      if (i == D - 1) begin : g_last
        assign next_e = ent[i];
      end else begin : g_next
        assign next_e = ent[i+1];
      end
      mqps_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .valid     (W'(i) < fill_r),
        .new_e     (new_e),
        .prev_e    (prev_e),
        .prev_disp (prev_disp),
        .next_e    (next_e),
        .e         (ent[i]),
        .disp      (disp[i])
      );
    end
  endgenerate

  assign head       = ent[0];
  assign stat.full  = (fill_r == W'(D));
  assign stat.empty = (fill_r == '0);

  always_comb begin
    fill_nxt = fill_r;
    if (ctl.clr) begin
      fill_nxt = '0;
    end else if (ctl.ins) begin
      fill_nxt = fill_r + W'(1);
    end else if (ctl.pop) begin
      fill_nxt = fill_r - W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

endmodule

>>> hw/rtl/mqps_checker.sv
module mqps_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input mqps_pkg::in_beat_t  in_data,
  input logic                out_valid,
  input mqps_pkg::out_beat_t out_data
);

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("command beat without result beat");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result beat without command beat");

  a_clear_status: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.cmd == mqps_pkg::CMD_CLEAR)
      |=> (out_data.status == mqps_pkg::ST_CLEARED))
    else $error("clear did not report cleared");

  a_zero_ticket: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != mqps_pkg::ST_INSERTED
      && out_data.status != mqps_pkg::ST_SERVED) |-> (out_data.ticket == '0))
    else $error("nonzero ticket on refused or control result");

  a_first_ticket: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == mqps_pkg::ST_CLEARED && start && !busy
      && in_data.cmd == mqps_pkg::CMD_INSERT && in_data.queue_sel == 2'd0)
      |=> (out_data.ticket == 16'd1))
    else $error("first insert after clear did not get ticket one");

endmodule

bind multi_queue_priority_fifo_scheduler mqps_checker u_mqps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

>>> test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mqps_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] QSEL_BAD   = 2'd3;
  localparam int         TICKET_MAX = (1 << TICKET_BITS) - 1;
  localparam int         RAND_ITEMS = 240;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_beat_t  in_data;
  logic      out_valid;
  out_beat_t out_data;

  multi_queue_priority_fifo_scheduler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  entry_t    slot_mem [NUM_QUEUES][QUEUE_DEPTH];
  int        depth_now [NUM_QUEUES];
  int        last_ticket;
  out_beat_t pending_results [$];
  int        fail_count;
  bit        no_gaps;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("FAIL");
    $finish;
  end

  function automatic out_beat_t schedule_outcome(input in_beat_t b);
    out_beat_t r;
    int        q;
    int        best;
    r.status = ST_BADQ;
    r.ticket = '0;
    q = b.queue_sel;
    case (b.cmd)
      CMD_CLEAR: begin
        foreach (depth_now[i]) depth_now[i] = 0;
        last_ticket = 0;
        r.status = ST_CLEARED;
      end
      CMD_INSERT: begin
        if (q >= NUM_QUEUES) begin
          if (last_ticket < TICKET_MAX) last_ticket++;
        end else if (depth_now[q] >= QUEUE_DEPTH || last_ticket >= TICKET_MAX) begin
          r.status = ST_FULL;
        end else begin
          last_ticket++;
          slot_mem[q][depth_now[q]].prio = b.priority_req;
          slot_mem[q][depth_now[q]].tick = TICKET_BITS'(last_ticket);
          depth_now[q]++;
          r.status = ST_INSERTED;
          r.ticket = TICKET_BITS'(last_ticket);
        end
      end
      CMD_POP: begin
        if (q < NUM_QUEUES) begin
          if (depth_now[q] == 0) begin
            r.status = ST_EMPTY;
          end else begin
            best = 0;
            for (int i = 1; i < depth_now[q]; i++) begin
              if (slot_mem[q][i].prio > slot_mem[q][best].prio ||
                  (slot_mem[q][i].prio == slot_mem[q][best].prio &&
                   slot_mem[q][i].tick < slot_mem[q][best].tick))
                best = i;
            end
            r.status = ST_SERVED;
            r.ticket = slot_mem[q][best].tick;
            for (int i = best; i + 1 < depth_now[q]; i++) slot_mem[q][i] = slot_mem[q][i + 1];
            depth_now[q]--;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic issue_cmd(input logic [1:0] c, input logic [1:0] q, input logic [3:0] p);
    in_beat_t b;
    b.cmd          = c;
    b.queue_sel    = q;
    b.priority_req = p;
    if (!no_gaps) begin
      while ($urandom_range(99) < 11) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start   <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (busy);
    pending_results.push_back(schedule_outcome(b));
  endtask

  always @(posedge clk) begin : check_results
    out_beat_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d ticket %0d", out_data.status, out_data.ticket);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, out_data.status);
          fail_count++;
        end
        if (out_data.ticket !== want.ticket) begin
          $error("ticket mismatch: expected %0d, got %0d", want.ticket, out_data.ticket);
          fail_count++;
        end
      end
    end
  end

  task automatic test_empty_and_bad;
    for (int q = 0; q < NUM_QUEUES; q++) issue_cmd(CMD_POP, 2'(q), 4'd0);
    issue_cmd(CMD_POP, QSEL_BAD, 4'd15);
    issue_cmd(CMD_UNUSED, 2'd0, 4'd0);
    issue_cmd(CMD_UNUSED, QSEL_BAD, 4'd15);
  endtask

  task automatic test_ordering;
    issue_cmd(CMD_INSERT, 2'd1, 4'd0);
    issue_cmd(CMD_INSERT, 2'd1, 4'd15);
    issue_cmd(CMD_INSERT, 2'd1, 4'd7);
    issue_cmd(CMD_INSERT, QSEL_BAD, 4'd9);
    issue_cmd(CMD_INSERT, 2'd1, 4'd15);
    issue_cmd(CMD_INSERT, 2'd1, 4'd7);
    issue_cmd(CMD_INSERT, 2'd0, 4'd3);
    issue_cmd(CMD_INSERT, 2'd2, 4'd12);
    repeat (6) issue_cmd(CMD_POP, 2'd1, 4'd0);
    issue_cmd(CMD_CLEAR, QSEL_BAD, 4'd15);
    issue_cmd(CMD_POP, 2'd0, 4'd0);
    issue_cmd(CMD_INSERT, 2'd2, 4'd5);
    issue_cmd(CMD_POP, 2'd2, 4'd0);
  endtask

  task automatic test_full_queue;
    issue_cmd(CMD_CLEAR, 2'd0, 4'd0);
    repeat (QUEUE_DEPTH) issue_cmd(CMD_INSERT, 2'd2, 4'($urandom_range(15)));
    issue_cmd(CMD_INSERT, 2'd2, 4'd15);
    issue_cmd(CMD_INSERT, 2'd0, 4'd1);
    issue_cmd(CMD_POP, 2'd2, 4'd0);
    issue_cmd(CMD_INSERT, 2'd2, 4'd4);
    repeat (QUEUE_DEPTH + 1) issue_cmd(CMD_POP, 2'd2, 4'd0);
  endtask

  task automatic test_random_traffic;
    int         r;
    logic [1:0] q;
    logic [3:0] p;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      no_gaps = (n >= 150 && n < 250);
      r = $urandom_range(99);
      q = 2'($urandom_range(NUM_QUEUES - 1));
      // bias toward a few high priorities to force ties
      p = $urandom_range(1) ? 4'($urandom_range(15)) : 4'(12 + $urandom_range(3));
      if (r < 48)      issue_cmd(CMD_INSERT, q, p);
      else if (r < 88) issue_cmd(CMD_POP, q, p);
      else if (r < 91) issue_cmd(CMD_INSERT, QSEL_BAD, p);
      else if (r < 94) issue_cmd(CMD_POP, QSEL_BAD, p);
      else if (r < 97) issue_cmd(CMD_UNUSED, 2'($urandom_range(3)), p);
      else             issue_cmd(CMD_CLEAR, 2'($urandom_range(3)), p);
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    fail_count  = 0;
    no_gaps     = 1'b0;
    last_ticket = 0;
    foreach (depth_now[i]) depth_now[i] = 0;
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_and_bad();
    test_ordering();
    test_full_queue();
    test_random_traffic();

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
